>>> design/ohr_pkg.sv
// Package for the ordered handle registry: sizes, request and status codes,
// table entry layout, request/response payloads and controller enums.
// No dependencies.
package ohr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH        = 3'd0,
    REQ_DUPLICATE   = 3'd1,
    REQ_REMOVE      = 3'd2,
    REQ_UNREF       = 3'd3,
    REQ_LOOKUP      = 3'd4,
    REQ_FIND_ROLE   = 3'd5,
    REQ_READ_CACHED = 3'd6,
    REQ_PURGE       = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EVICTED   = 2'd2,
    ST_ZERO_KEY  = 2'd3
  } status_t;

  localparam logic [1:0] ROLE_PRIMARY = 2'd0;
  localparam logic [1:0] ROLE_BACK    = 2'd1;
  localparam logic [1:0] ROLE_DEPTH   = 2'd2;
  localparam logic [1:0] ROLE_3D      = 2'd3;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [1:0]          role;
    logic                referenced;
    logic [15:0]         version;
    logic [31:0]         caps;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    req_type_t           req_type;
    logic [KEY_BITS-1:0] key;
    logic [KEY_BITS-1:0] dest_key;
    logic [1:0]          role_in;
    logic [15:0]         version_in;
    logic [31:0]         caps_in;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [KEY_BITS-1:0] key_out;
    logic [1:0]          role_out;
    logic [15:0]         version_out;
    logic [31:0]         caps_out;
    logic                referenced_out;
    logic [6:0]          entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FIN,
    S_REPLY
  } state_t;

  typedef enum logic [1:0] {
    M_KEY,
    M_ROLE,
    M_COMPACT
  } mode_t;

endpackage

>>> design/ohr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ohr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/ordered_handle_registry_top.sv
// Ordered handle registry top level: request sequencer around the entry RAM.
// Depends on ohr_pkg and ohr_ram.
//
// Usage:
//   req/req_valid/req_ready carries one request per transfer; rsp/rsp_valid/
//   rsp_ready returns exactly one response per request, in order.
//   Requests are handled one at a time; req_ready is high only while the
//   sequencer is idle. Entries live in one RAM, oldest at slot 0.
// Each walk issues one RAM read per cycle over the valid entries, and the read
// data returns the cycle after its issue. Zero-key and read_cached requests
// skip the walk. Lookup, unref, find_by_role, purge and a push without
// eviction walk once; remove walks and then compacts the later slots; a push
// into a full table walks and then shifts every entry down one slot; a
// duplicate walks for the source key, then for the destination key, and
// shifts as well if it evicts.
// Reset clears the entry count and the per-role caches; no RAM clearing pass.
// A response waits in the output register while rsp_ready is low; the
// sequencer holds the next response until that register frees up, and
// a new request is taken the cycle after the previous one reaches it.
module ordered_handle_registry_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ohr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ohr_pkg::rsp_t rsp
);
  import ohr_pkg::*;

  state_t              state, state_next;
  mode_t               mode, mode_next;
  req_t                cur, cur_next;
  rsp_t                res, res_next;
  rsp_t                rsp_next;
  logic                rsp_valid_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    ridx, ridx_next;
  logic [CNT_W-1:0]    j, j_next;
  logic [IDX_W-1:0]    cidx, cidx_next;
  logic [IDX_W-1:0]    slot, slot_next;
  logic                pend, pend_next;
  logic                hit, hit_next;
  logic                keep_all, keep_all_next;
  logic                phase, phase_next;
  logic                evict, evict_next;
  logic [KEY_BITS-1:0] skey, skey_next;
  entry_t              ent, ent_next;
  logic [1:0]          srole, srole_next;
  logic [31:0]         scaps, scaps_next;
  logic [KEY_BITS-1:0] c_prim, c_prim_next;
  logic [KEY_BITS-1:0] c_back, c_back_next;
  logic [KEY_BITS-1:0] c_depth, c_depth_next;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  entry_t              rd;

  logic                accept, zero_key, immediate, issue, key_hit, scan_end;
  logic                is_dup, claim, full, decide_scan, rsp_free;
  entry_t              newent;

  ohr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ridx[IDX_W-1:0]),
    .rdata (rd)
  );

  // shared control decisions
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign zero_key  = ((req.req_type == REQ_PUSH) || (req.req_type == REQ_DUPLICATE) ||
                      (req.req_type == REQ_REMOVE) || (req.req_type == REQ_UNREF) ||
                      (req.req_type == REQ_LOOKUP)) && (req.key == '0) ||
                     (req.req_type == REQ_DUPLICATE) && (req.dest_key == '0);
  assign immediate = zero_key || (req.req_type == REQ_READ_CACHED);
  assign issue     = (ridx < cnt);
  assign key_hit   = pend && (mode == M_KEY) && (rd.key == skey);
  assign scan_end  = !pend && !issue;
  assign is_dup    = (cur.req_type == REQ_DUPLICATE);
  assign claim     = (cur.req_type == REQ_PUSH) || (is_dup && phase);
  assign full      = (cnt == CNT_W'(TABLE_DEPTH));
  assign decide_scan = (claim && !hit && full) ||
                       (is_dup && !phase && hit) ||
                       ((cur.req_type == REQ_REMOVE) && hit);
  assign rsp_free  = !rsp_valid || rsp_ready;

  // entry written by push or duplicate
  always_comb begin
    newent.key        = skey;
    newent.role       = is_dup ? srole : cur.role_in;
    newent.referenced = 1'b1;
    newent.version    = cur.version_in;
    newent.caps       = is_dup ? scaps : cur.caps_in;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = immediate ? S_REPLY : S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          state_next = S_DECIDE;
        end else if (scan_end) begin
          state_next = (mode == M_COMPACT) ? S_FIN : S_DECIDE;
        end
      end
      S_DECIDE: state_next = decide_scan ? S_SCAN : S_REPLY;
      S_FIN:    state_next = S_REPLY;
      S_REPLY: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    mode_next      = mode;
    cur_next       = cur;
    res_next       = res;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cnt_next       = cnt;
    ridx_next      = ridx;
    j_next         = j;
    cidx_next      = cidx;
    slot_next      = slot;
    pend_next      = pend;
    hit_next       = hit;
    keep_all_next  = keep_all;
    phase_next     = phase;
    evict_next     = evict;
    skey_next      = skey;
    ent_next       = ent;
    srole_next     = srole;
    scaps_next     = scaps;
    c_prim_next    = c_prim;
    c_back_next    = c_back;
    c_depth_next   = c_depth;
    ram_we         = 1'b0;
    ram_waddr      = slot;
    ram_wdata      = newent;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next   = req;
          hit_next   = 1'b0;
          pend_next  = 1'b0;
          phase_next = 1'b0;
          evict_next = 1'b0;
          skey_next  = req.key;
          ridx_next  = '0;
          j_next     = '0;
          res_next   = '0;
          if (zero_key) begin
            res_next.status = ST_ZERO_KEY;
          end else if (req.req_type == REQ_READ_CACHED) begin
            unique case (req.role_in)
              ROLE_PRIMARY: res_next.key_out = c_prim;
              ROLE_BACK:    res_next.key_out = c_back;
              ROLE_DEPTH:   res_next.key_out = c_depth;
              default:      res_next.key_out = '0;
            endcase
            res_next.status = (res_next.key_out == '0) ? ST_NOT_FOUND : ST_OK;
          end else if (req.req_type == REQ_PURGE) begin
            c_prim_next   = '0;
            c_back_next   = '0;
            c_depth_next  = '0;
            mode_next     = M_COMPACT;
            keep_all_next = 1'b0;
          end else if (req.req_type == REQ_FIND_ROLE) begin
            mode_next = M_ROLE;
          end else begin
            mode_next = M_KEY;
          end
        end
      end

      // walk: issue one read per cycle, examine the previous read's data
      S_SCAN: begin
        pend_next = issue;
        if (issue) begin
          ridx_next = ridx + 1'b1;
          cidx_next = ridx[IDX_W-1:0];
        end
        if (pend) begin
          unique case (mode)
            M_KEY: begin
              if (rd.key == skey) begin
                hit_next  = 1'b1;
                slot_next = cidx;
                ent_next  = rd;
              end
            end
            M_ROLE: begin
              if ((rd.role == cur.role_in) && rd.referenced) begin
                hit_next = 1'b1;
                ent_next = rd;
              end
            end
            default: begin
              if (keep_all || rd.referenced) begin
                ram_we    = 1'b1;
                ram_waddr = j[IDX_W-1:0];
                ram_wdata = rd;
                j_next    = j + 1'b1;
                if (!keep_all) begin
                  unique case (rd.role)
                    ROLE_PRIMARY: c_prim_next  = rd.key;
                    ROLE_BACK:    c_back_next  = rd.key;
                    ROLE_DEPTH:   c_depth_next = rd.key;
                    default:      ;
                  endcase
                end
              end
            end
          endcase
        end else if (!issue && (mode == M_COMPACT)) begin
          cnt_next = j;
        end
      end

      S_DECIDE: begin
        pend_next = 1'b0;
        if (claim) begin
          res_next.caps_out = is_dup ? scaps : '0;
          if (hit || !full) begin
            ram_we    = 1'b1;
            ram_waddr = hit ? slot : cnt[IDX_W-1:0];
            if (!hit) begin
              cnt_next = cnt + 1'b1;
            end
            res_next.status = ST_OK;
            if (!is_dup) begin
              unique case (cur.role_in)
                ROLE_PRIMARY: c_prim_next  = skey;
                ROLE_BACK:    c_back_next  = skey;
                ROLE_DEPTH:   c_depth_next = skey;
                default:      ;
              endcase
            end
          end else begin
            // full: drop the oldest by shifting everything down one slot
            evict_next    = 1'b1;
            mode_next     = M_COMPACT;
            keep_all_next = 1'b1;
            ridx_next     = CNT_W'(1);
            j_next        = '0;
          end
        end else begin
          unique case (cur.req_type)
            REQ_DUPLICATE: begin
              if (!hit) begin
                res_next.status = ST_NOT_FOUND;
              end else begin
                srole_next = ent.role;
                scaps_next = ent.caps;
                phase_next = 1'b1;
                skey_next  = cur.dest_key;
                mode_next  = M_KEY;
                ridx_next  = '0;
                hit_next   = 1'b0;
              end
            end
            REQ_REMOVE: begin
              if (!hit) begin
                res_next.status = ST_NOT_FOUND;
              end else begin
                mode_next     = M_COMPACT;
                keep_all_next = 1'b1;
                ridx_next     = CNT_W'(slot) + 1'b1;
                j_next        = CNT_W'(slot);
              end
            end
            REQ_UNREF: begin
              if (!hit) begin
                res_next.status = ST_NOT_FOUND;
              end else begin
                ram_we               = 1'b1;
                ram_waddr            = slot;
                ram_wdata            = ent;
                ram_wdata.referenced = 1'b0;
              end
            end
            REQ_LOOKUP, REQ_FIND_ROLE: begin
              if (!hit) begin
                res_next.status = ST_NOT_FOUND;
              end else begin
                res_next.key_out        = (cur.req_type == REQ_FIND_ROLE) ? ent.key : '0;
                res_next.role_out       = ent.role;
                res_next.version_out    = ent.version;
                res_next.caps_out       = ent.caps;
                res_next.referenced_out = ent.referenced;
              end
            end
            default: ;
          endcase
        end
      end

      // end of a compaction walk
      S_FIN: begin
        if (claim) begin
          ram_we            = 1'b1;
          ram_waddr         = cnt[IDX_W-1:0];
          cnt_next          = cnt + 1'b1;
          res_next.status   = evict ? ST_EVICTED : ST_OK;
          res_next.caps_out = is_dup ? scaps : '0;
          if (!is_dup) begin
            unique case (cur.role_in)
              ROLE_PRIMARY: c_prim_next  = skey;
              ROLE_BACK:    c_back_next  = skey;
              ROLE_DEPTH:   c_depth_next = skey;
              default:      ;
            endcase
          end
        end else begin
          res_next.status = ST_OK;
        end
      end

      S_REPLY: begin
        if (rsp_free) begin
          rsp_next             = res;
          rsp_next.entry_count = 7'(cnt);
          rsp_valid_next       = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      c_prim    <= '0;
      c_back    <= '0;
      c_depth   <= '0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      cnt       <= cnt_next;
      c_prim    <= c_prim_next;
      c_back    <= c_back_next;
      c_depth   <= c_depth_next;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    mode     <= mode_next;
    cur      <= cur_next;
    res      <= res_next;
    rsp      <= rsp_next;
    ridx     <= ridx_next;
    j        <= j_next;
    cidx     <= cidx_next;
    slot     <= slot_next;
    pend     <= pend_next;
    hit      <= hit_next;
    keep_all <= keep_all_next;
    phase    <= phase_next;
    evict    <= evict_next;
    skey     <= skey_next;
    ent      <= ent_next;
    srole    <= srole_next;
    scaps    <= scaps_next;
  end

endmodule
